FILE: rtl/core/i2a_pkg.sv
// shared types, codes and helpers for the integer to ascii digit emitter
`default_nettype none

package i2a_pkg;

    // default word width of the converted value
    localparam int WORD_BITS_DEF = 32;

    // conversion mode codes carried on the opcode field
    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    // ascii codes
    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_NINE  = 7'h39;
    localparam logic [6:0] CHAR_A     = 7'h61;
    localparam logic [6:0] CHAR_F     = 7'h66;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic dabble;
        logic dig_shift;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic hex;
        logic neg;
        logic conv_last;
        logic top_zero;
        logic dig_last;
    } t_dp_sts;

    // one digit to its lowercase ascii character
    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {3'b000, d};
        end else begin
            c = CHAR_A + {3'b000, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/i2a_ctrl.sv
// controller state machine of the integer to ascii digit emitter
`default_nettype none

module i2a_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    output logic              o_busy,
    output i2a_pkg::t_dp_cmd  o_cmd,
    input  i2a_pkg::t_dp_sts  i_sts
);

    i2a_pkg::t_state r_state;
    i2a_pkg::t_state n_state;
    logic            skip_zero;

    // leading zero that is not the final digit
    assign skip_zero = i_sts.top_zero && !i_sts.dig_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2a_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            i2a_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = i2a_pkg::ST_PREP;
                end
            end
            i2a_pkg::ST_PREP: begin
                n_state = i_sts.hex ? i2a_pkg::ST_SKIP : i2a_pkg::ST_CONV;
            end
            i2a_pkg::ST_CONV: begin
                if (i_sts.conv_last) begin
                    n_state = i_sts.neg ? i2a_pkg::ST_SIGN : i2a_pkg::ST_SKIP;
                end
            end
            i2a_pkg::ST_SIGN: begin
                n_state = i2a_pkg::ST_SKIP;
            end
            i2a_pkg::ST_SKIP: begin
                if (!skip_zero) begin
                    n_state = i_sts.dig_last ? i2a_pkg::ST_IDLE : i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_EMIT: begin
                if (i_sts.dig_last) begin
                    n_state = i2a_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            i2a_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            i2a_pkg::ST_PREP: begin
            end
            i2a_pkg::ST_CONV: begin
                o_cmd.dabble = 1'b1;
            end
            i2a_pkg::ST_SIGN: begin
                o_cmd.emit_sign = 1'b1;
            end
            i2a_pkg::ST_SKIP: begin
                o_cmd.dig_shift  = 1'b1;
                o_cmd.emit_digit = !skip_zero;
            end
            i2a_pkg::ST_EMIT: begin
                o_cmd.dig_shift  = 1'b1;
                o_cmd.emit_digit = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

    a_idle_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> !(o_cmd.emit_digit || o_cmd.emit_sign || o_cmd.dabble))
        else $error("work command while idle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted beat did not raise busy");

    a_sign_before_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_sign |-> (i_sts.neg && !i_sts.hex))
        else $error("sign emitted for a non-negative decimal value");

endmodule

`default_nettype wire

FILE: rtl/core/i2a_datapath.sv
// datapath: magnitude, double dabble bcd conversion and digit emission
`default_nettype none

module i2a_datapath #(
    parameter int WORD_BITS  = i2a_pkg::WORD_BITS_DEF,
    parameter int DEC_DIGITS = (WORD_BITS * 1233) / 4096 + 1,
    parameter int HEX_DIGITS = (WORD_BITS + 3) / 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_opcode,
    input  wire [WORD_BITS-1:0]  i_value,
    input  i2a_pkg::t_dp_cmd     i_cmd,
    output i2a_pkg::t_dp_sts     o_sts,
    output logic [6:0]           o_ascii_char,
    output logic                 o_last_char,
    output logic                 o_valid
);

    localparam int DIG_W     = 4 * DEC_DIGITS;
    localparam int HEX_SHIFT = 4 * (DEC_DIGITS - HEX_DIGITS);
    localparam int CNT_W     = $clog2(WORD_BITS + 1);
    localparam int LEFT_W    = $clog2(DEC_DIGITS + 1);

    logic [WORD_BITS-1:0] r_bin,  n_bin;
    logic [DIG_W-1:0]     r_dig,  n_dig;
    logic [CNT_W-1:0]     r_cnt,  n_cnt;
    logic [LEFT_W-1:0]    r_left, n_left;
    logic                 r_hex,  n_hex;
    logic                 r_neg,  n_neg;
    logic [6:0]           r_char, n_char;
    logic                 r_last, n_last;
    logic                 r_valid, n_valid;

    logic                 ld_neg;
    logic [WORD_BITS-1:0] ld_mag;
    logic [DIG_W-1:0]     adj;
    logic [3:0]           top_dig;

    assign ld_neg  = (i_opcode == i2a_pkg::OP_DEC) && i_value[WORD_BITS-1];
    assign ld_mag  = ld_neg ? (~i_value + WORD_BITS'(1)) : i_value;
    assign top_dig = r_dig[DIG_W-1 -: 4];

    // add three to every bcd digit of five or more
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r_dig[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_dig[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_dig[4*i +: 4];
            end
        end
    end

    always_comb begin
        n_bin   = r_bin;
        n_dig   = r_dig;
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_hex   = r_hex;
        n_neg   = r_neg;
        n_char  = r_char;
        n_last  = r_last;
        n_valid = i_cmd.emit_sign || i_cmd.emit_digit;
        if (i_cmd.load) begin
            n_hex = (i_opcode == i2a_pkg::OP_HEX);
            n_neg = ld_neg;
            n_bin = ld_mag;
            n_cnt = CNT_W'(WORD_BITS);
            if (i_opcode == i2a_pkg::OP_HEX) begin
                n_dig  = DIG_W'(ld_mag) << HEX_SHIFT;
                n_left = LEFT_W'(HEX_DIGITS);
            end else begin
                n_dig  = '0;
                n_left = LEFT_W'(DEC_DIGITS);
            end
        end
        if (i_cmd.dabble) begin
            n_dig = {adj[DIG_W-2:0], r_bin[WORD_BITS-1]};
            n_bin = {r_bin[WORD_BITS-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
        end
        if (i_cmd.emit_sign) begin
            n_char = i2a_pkg::CHAR_MINUS;
            n_last = 1'b0;
        end
        if (i_cmd.emit_digit) begin
            n_char = i2a_pkg::digit_char(top_dig);
            n_last = (r_left == LEFT_W'(1));
        end
        if (i_cmd.dig_shift) begin
            n_dig  = r_dig << 4;
            n_left = r_left - LEFT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_valid <= n_valid;
        end
        r_bin  <= n_bin;
        r_dig  <= n_dig;
        r_hex  <= n_hex;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_sts.hex       = r_hex;
    assign o_sts.neg       = r_neg;
    assign o_sts.conv_last = (r_cnt == CNT_W'(1));
    assign o_sts.top_zero  = (top_dig == 4'd0);
    assign o_sts.dig_last  = (r_left == LEFT_W'(1));

    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;
    assign o_valid      = r_valid;

    a_dabble_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dabble |-> (r_cnt != '0))
        else $error("bcd shift beyond word width");

    a_digit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_digit |-> (r_left != '0))
        else $error("digit emitted with no digits left");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_ascii_char == i2a_pkg::CHAR_MINUS)
            || ((o_ascii_char >= i2a_pkg::CHAR_ZERO) && (o_ascii_char <= i2a_pkg::CHAR_NINE))
            || ((o_ascii_char >= i2a_pkg::CHAR_A) && (o_ascii_char <= i2a_pkg::CHAR_F))))
        else $error("character outside digit set");

endmodule

`default_nettype wire

FILE: rtl/core/integer_to_ascii_digits.sv
// top level of the integer to ascii digit emitter
//
//  channel   | ports                               | handshake
//  ----------+-------------------------------------+-------------------------------
//  command   | i_opcode, i_value                   | taken when start high, busy low
//  result    | o_ascii_char, o_last_char           | o_valid strobe, one cycle each
//
// one value is worked on at a time; busy stays high until its last character
// is issued. decimal values first pass through the one-bit-per-cycle double dabble
// shift register and then an optional minus sign; hex values skip both.
// digit characters leave one per cycle once the leading zeros are skipped,
// and the strobe follows the controller's command in the next cycle.
// reset is synchronous, active low, and clears the controller and the strobe.
// the receiver cannot stall; every beat is taken on the cycle it is shown.
`default_nettype none

module integer_to_ascii_digits #(
    parameter int WORD_BITS = i2a_pkg::WORD_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire                  i_opcode,
    input  wire [WORD_BITS-1:0]  i_value,
    output logic [6:0]           o_ascii_char,
    output logic                 o_last_char,
    output logic                 o_valid
);

    // decimal digits of the largest word, and hex digits of the word
    localparam int DEC_DIGITS = (WORD_BITS * 1233) / 4096 + 1;
    localparam int HEX_DIGITS = (WORD_BITS + 3) / 4;

    i2a_pkg::t_dp_cmd cmd;
    i2a_pkg::t_dp_sts sts;

    // sequencing: load, bcd shifting, sign, leading zero skip, emit
    i2a_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // magnitude, digit register and registered character output
    i2a_datapath #(
        .WORD_BITS  (WORD_BITS),
        .DEC_DIGITS (DEC_DIGITS),
        .HEX_DIGITS (HEX_DIGITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char),
        .o_valid      (o_valid)
    );

endmodule

`default_nettype wire
